@@ src/mpr_pkg.sv @@
// ----------------------------------------------------------------------------
// mpr_pkg
// Opcodes, register indexes and pixel modes of the page raster plotter.
// ----------------------------------------------------------------------------
package mpr_pkg;

   typedef logic [2:0] opcode_type;
   typedef logic [1:0] mode_type;

   localparam opcode_type OP_POINT      = 3'd0;
   localparam opcode_type OP_HFILL      = 3'd1;
   localparam opcode_type OP_HINVERT    = 3'd2;
   localparam opcode_type OP_VFILL      = 3'd3;
   localparam opcode_type OP_VINVERT    = 3'd4;
   localparam opcode_type OP_BLIT_START = 3'd5;
   localparam opcode_type OP_BLIT_BITS  = 3'd6;
   localparam opcode_type OP_CLEAR      = 3'd7;

   localparam logic [2:0] REG_CLIP_LEFT   = 3'd0;
   localparam logic [2:0] REG_CLIP_RIGHT  = 3'd1;
   localparam logic [2:0] REG_CLIP_TOP    = 3'd2;
   localparam logic [2:0] REG_CLIP_BOTTOM = 3'd3;
   localparam logic [2:0] REG_FG_BLACK    = 3'd4;

   localparam mode_type MODE_SET    = 2'd0;
   localparam mode_type MODE_CLEAR  = 2'd1;
   localparam mode_type MODE_TOGGLE = 2'd2;

   localparam logic [7:0] CLIP_RIGHT_RESET  = 8'd131;
   localparam logic [6:0] CLIP_BOTTOM_RESET = 7'd64;

   function automatic logic [7:0] apply_mode(input logic [7:0] data, input logic [7:0] mask,
                                             input mode_type mode);
      logic [7:0] res;
      case (mode)
         MODE_CLEAR:  res = data & ~mask;
         MODE_TOGGLE: res = data ^ mask;
         default:     res = data | mask;
      endcase
      return res;
   endfunction

endpackage

@@ src/monochrome_page_raster_plotter_top.sv @@
// ----------------------------------------------------------------------------
// monochrome_page_raster_plotter_top
// Page-organised 1-bit frame store with point, run and clipped blit drawing.
// ----------------------------------------------------------------------------
// Use:
//  req_* stream carries one command per transfer (opcode in tuser). Every
//  command returns exactly one rsp_* transfer: the store byte at
//  read_page/read_column after the command, plus the blit-active flag.
//  csr_* is a plain write port for the clip window and foreground colour;
//  write it only while no command is in flight.
// Sequence (one command at a time, frame store is a single registered-read RAM):
//  point / runs: each drawn pixel is read, then modified and written back;
//  the first pixel that fails the clip or end test ends the run, then read-out.
//  blit start: window arithmetic, then read-out. blit bits: a skipped or
//  blank bit is stepped over, a drawn bit is read and then written back.
//  clear: sweeps all PAGES*COLUMNS bytes (1056 by default) to zero, then reads.
// Reset: the same clearing sweep runs with req_tready low; the clip window
//  returns to the full page.
// Stall: the result sits in an output register; the next command is taken
//  while it waits, only its own result waits for rsp_tready.
// ----------------------------------------------------------------------------
module monochrome_page_raster_plotter_top
   import mpr_pkg::*;
#(
   parameter int PAGES   = 8,
   parameter int COLUMNS = 132
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [8:0] x_start, [17:9] x_end, [25:18] y_start, [33:26] y_end,
   // [41:34] blit_width, [49:42] blit_rows, [57:50] source_bits,
   // [60:58] read_page, [68:61] read_column, [71:69] zero
   input  logic [71:0] req_tdata,
   // [2:0] opcode
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] read_data
   output logic [7:0]  rsp_tdata,
   // [0] blit_active
   output logic        rsp_tuser,
   input  logic        csr_we,
   input  logic [2:0]  csr_addr,
   input  logic [7:0]  csr_wdata
);

   localparam int ROWS   = PAGES * 8;
   localparam int DEPTH  = PAGES * COLUMNS;
   localparam int ADDR_W = $clog2(DEPTH);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_CLEAR    = 4'd1;
   localparam logic [3:0] S_START    = 4'd2;
   localparam logic [3:0] S_WALK_RD  = 4'd3;
   localparam logic [3:0] S_WALK_WR  = 4'd4;
   localparam logic [3:0] S_FEED_BIT = 4'd5;
   localparam logic [3:0] S_FEED_WR  = 4'd6;
   localparam logic [3:0] S_RD_ISSUE = 4'd7;
   localparam logic [3:0] S_RD_CAP   = 4'd8;

   // request fields
   logic signed [8:0] f_xs, f_xe;
   logic signed [7:0] f_ys, f_ye;
   logic [7:0]        f_bw, f_br, f_src, f_rc;
   logic [2:0]        f_rp;
   assign f_xs  = $signed(req_tdata[8:0]);
   assign f_xe  = $signed(req_tdata[17:9]);
   assign f_ys  = $signed(req_tdata[25:18]);
   assign f_ye  = $signed(req_tdata[33:26]);
   assign f_bw  = req_tdata[41:34];
   assign f_br  = req_tdata[49:42];
   assign f_src = req_tdata[57:50];
   assign f_rp  = req_tdata[60:58];
   assign f_rc  = req_tdata[68:61];

   // registers
   logic [3:0]         state_ff, state_in;
   logic [ADDR_W-1:0]  clr_cnt_ff, clr_cnt_in;
   logic               pend_ff, pend_in;
   logic [7:0]         clip_left_ff, clip_right_ff;
   logic [5:0]         clip_top_ff;
   logic [6:0]         clip_bottom_ff;
   logic               fg_black_ff;
   // walker
   logic signed [10:0] wx_ff, wx_in, wxe_ff, wxe_in;
   logic signed [9:0]  wy_ff, wy_in, wye_ff, wye_in;
   logic               wvert_ff, wvert_in;
   mode_type           wmode_ff, wmode_in;
   // latched command payload
   logic signed [8:0]  cxs_ff, cxs_in;
   logic signed [7:0]  cys_ff, cys_in;
   logic [7:0]         cbw_ff, cbw_in, cbr_ff, cbr_in, csrc_ff, csrc_in, crc_ff, crc_in;
   logic [2:0]         crp_ff, crp_in;
   logic [3:0]         bit_cnt_ff, bit_cnt_in;
   // blit state
   logic signed [10:0] b_col_ff, b_col_in, b_left_ff, b_left_in, b_right_ff, b_right_in;
   logic signed [9:0]  b_row_ff, b_row_in;
   logic [7:0]         b_rows_ff, b_rows_in;
   logic [15:0]        b_skip_ff, b_skip_in;
   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_data_ff, rsp_data_in;
   logic               rsp_act_ff, rsp_act_in;

   // frame store
   logic [7:0]         mem [DEPTH];
   logic [7:0]         mem_rd_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa, mem_ra;
   logic [7:0]         mem_wd;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   // shared pixel address and clip test
   logic               feeding;
   logic signed [10:0] px;
   logic signed [9:0]  py;
   logic               col_ok, row_ok, walk_ok;
   logic [ADDR_W-1:0]  pix_addr, rd_addr;
   logic [7:0]         pix_mask;
   logic               rd_in_range;
   mode_type           draw_mode;

   assign feeding   = (state_ff == S_FEED_BIT) || (state_ff == S_FEED_WR);
   assign px        = feeding ? b_col_ff : wx_ff;
   assign py        = feeding ? b_row_ff : wy_ff;
   assign draw_mode = fg_black_ff ? MODE_CLEAR : MODE_SET;
   assign col_ok = (px >= $signed(11'(clip_left_ff))) && (px <= $signed(11'(clip_right_ff)))
                   && (px >= 11'sd0) && (px < $signed(11'(COLUMNS)));
   assign row_ok = (py >= $signed(10'(clip_top_ff))) && (py < $signed(10'(clip_bottom_ff)))
                   && (py >= 10'sd0) && (py < $signed(10'(ROWS)));
   assign walk_ok  = col_ok && row_ok && (wvert_ff ? (wy_ff <= wye_ff) : (wx_ff <= wxe_ff));
   assign pix_addr = ADDR_W'(32'(py[8:3]) * COLUMNS + 32'(px[7:0]));
   assign pix_mask = 8'd1 << py[2:0];
   assign rd_in_range = (32'(crp_ff) < PAGES) && (32'(crc_ff) < COLUMNS);
   assign rd_addr  = ADDR_W'(32'(crp_ff) * COLUMNS + 32'(crc_ff));

   // blit start arithmetic
   logic signed [10:0] st_off, st_y0, st_end;
   logic [8:0]         st_rows;
   logic [15:0]        st_skip;
   logic               st_void;

   // blit column advance
   logic signed [10:0] b_next_col;
   assign b_next_col = b_col_ff + 11'sd1;

   always_comb begin
      state_in     = state_ff;
      clr_cnt_in   = clr_cnt_ff;
      pend_in      = pend_ff;
      wx_in        = wx_ff;
      wxe_in       = wxe_ff;
      wy_in        = wy_ff;
      wye_in       = wye_ff;
      wvert_in     = wvert_ff;
      wmode_in     = wmode_ff;
      cxs_in       = cxs_ff;
      cys_in       = cys_ff;
      cbw_in       = cbw_ff;
      cbr_in       = cbr_ff;
      csrc_in      = csrc_ff;
      crp_in       = crp_ff;
      crc_in       = crc_ff;
      bit_cnt_in   = bit_cnt_ff;
      b_col_in     = b_col_ff;
      b_left_in    = b_left_ff;
      b_right_in   = b_right_ff;
      b_row_in     = b_row_ff;
      b_rows_in    = b_rows_ff;
      b_skip_in    = b_skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_act_in   = rsp_act_ff;
      mem_we       = 1'b0;
      mem_wa       = pix_addr;
      mem_ra       = pix_addr;
      mem_wd       = apply_mode(mem_rd_ff, pix_mask, feeding ? draw_mode : wmode_ff);
      req_tready   = (state_ff == S_IDLE);

      st_off  = 11'(clip_top_ff) - 11'(cys_ff);
      st_y0   = 11'(cys_ff);
      st_rows = 9'(cbr_ff);
      st_skip = 16'd0;
      st_void = (cbw_ff == 8'd0) || (cbr_ff == 8'd0);
      if (11'(cys_ff) < $signed(11'(clip_top_ff))) begin
         if (st_off >= $signed(11'(cbr_ff))) begin
            st_void = 1'b1;
         end
         st_y0   = 11'(clip_top_ff);
         st_rows = 9'(cbr_ff) - st_off[8:0];
         st_skip = st_off[7:0] * cbw_ff;
      end
      if (st_y0 >= $signed(11'(clip_bottom_ff))) begin
         st_void = 1'b1;
      end
      st_end = st_y0 + $signed(11'(st_rows));
      if (st_end > $signed(11'(clip_bottom_ff))) begin
         st_rows = 9'($signed(11'(clip_bottom_ff)) - st_y0);
      end

      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               pend_in  = 1'b1;
               cxs_in   = f_xs;
               cys_in   = f_ys;
               cbw_in   = f_bw;
               cbr_in   = f_br;
               csrc_in  = f_src;
               crp_in   = f_rp;
               crc_in   = f_rc;
               wx_in    = 11'(f_xs);
               wy_in    = 10'(f_ys);
               wxe_in   = 11'(f_xe);
               wye_in   = 10'(f_ye);
               wvert_in = 1'b0;
               wmode_in = draw_mode;
               bit_cnt_in = 4'd0;
               case (req_tuser)
                  OP_POINT: begin
                     wxe_in   = 11'(f_xs);
                     state_in = S_WALK_RD;
                  end
                  OP_HFILL: state_in = S_WALK_RD;
                  OP_HINVERT: begin
                     wmode_in = MODE_TOGGLE;
                     state_in = S_WALK_RD;
                  end
                  OP_VFILL, OP_VINVERT: begin
                     wvert_in = 1'b1;
                     if (req_tuser == OP_VINVERT) begin
                        wmode_in = MODE_TOGGLE;
                     end
                     // start row raised to the top of the window
                     if (10'(f_ys) <= $signed(10'(clip_top_ff))) begin
                        wy_in = 10'(clip_top_ff);
                     end
                     state_in = S_WALK_RD;
                  end
                  OP_BLIT_START: state_in = S_START;
                  OP_BLIT_BITS: begin
                     state_in = (b_rows_ff == 8'd0) ? S_RD_ISSUE : S_FEED_BIT;
                  end
                  default: begin
                     clr_cnt_in = '0;
                     state_in   = S_CLEAR;
                  end
               endcase
            end
         end
         S_CLEAR: begin
            mem_we     = 1'b1;
            mem_wa     = clr_cnt_ff;
            mem_wd     = 8'd0;
            clr_cnt_in = clr_cnt_ff + 1'b1;
            if (clr_cnt_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = pend_ff ? S_RD_ISSUE : S_IDLE;
            end
         end
         S_START: begin
            b_rows_in = 8'd0;
            b_skip_in = 16'd0;
            if (!st_void) begin
               b_left_in  = 11'(cxs_ff);
               b_right_in = 11'(cxs_ff) + $signed(11'(cbw_ff));
               b_col_in   = 11'(cxs_ff);
               b_row_in   = st_y0[9:0];
               b_rows_in  = st_rows[7:0];
               b_skip_in  = st_skip;
            end
            state_in = S_RD_ISSUE;
         end
         S_WALK_RD: begin
            state_in = walk_ok ? S_WALK_WR : S_RD_ISSUE;
         end
         S_WALK_WR: begin
            mem_we = 1'b1;
            if (wvert_ff) begin
               wy_in = wy_ff + 10'sd1;
            end else begin
               wx_in = wx_ff + 11'sd1;
            end
            state_in = S_WALK_RD;
         end
         S_FEED_BIT: begin
            if (bit_cnt_ff[3] || (b_rows_ff == 8'd0)) begin
               state_in = S_RD_ISSUE;
            end else if (b_skip_ff != 16'd0) begin
               b_skip_in  = b_skip_ff - 16'd1;
               bit_cnt_in = bit_cnt_ff + 4'd1;
            end else if (csrc_ff[bit_cnt_ff[2:0]] && col_ok && row_ok) begin
               state_in = S_FEED_WR;
            end else begin
               bit_cnt_in = bit_cnt_ff + 4'd1;
               if (b_next_col >= b_right_ff) begin
                  b_col_in  = b_left_ff;
                  b_row_in  = b_row_ff + 10'sd1;
                  b_rows_in = b_rows_ff - 8'd1;
               end else begin
                  b_col_in = b_next_col;
               end
            end
         end
         S_FEED_WR: begin
            mem_we     = 1'b1;
            bit_cnt_in = bit_cnt_ff + 4'd1;
            if (b_next_col >= b_right_ff) begin
               b_col_in  = b_left_ff;
               b_row_in  = b_row_ff + 10'sd1;
               b_rows_in = b_rows_ff - 8'd1;
            end else begin
               b_col_in = b_next_col;
            end
            state_in = S_FEED_BIT;
         end
         S_RD_ISSUE: begin
            mem_ra   = rd_addr;
            state_in = S_RD_CAP;
         end
         S_RD_CAP: begin
            mem_ra = rd_addr;
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = rd_in_range ? mem_rd_ff : 8'd0;
               rsp_act_in   = (b_rows_ff != 8'd0);
               pend_in      = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_CLEAR;
         clr_cnt_ff     <= '0;
         pend_ff        <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         clip_left_ff   <= 8'd0;
         clip_right_ff  <= CLIP_RIGHT_RESET;
         clip_top_ff    <= 6'd0;
         clip_bottom_ff <= CLIP_BOTTOM_RESET;
         fg_black_ff    <= 1'b0;
         b_col_ff       <= '0;
         b_left_ff      <= '0;
         b_right_ff     <= '0;
         b_row_ff       <= '0;
         b_rows_ff      <= 8'd0;
         b_skip_ff      <= 16'd0;
         bit_cnt_ff     <= 4'd0;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
         b_col_ff     <= b_col_in;
         b_left_ff    <= b_left_in;
         b_right_ff   <= b_right_in;
         b_row_ff     <= b_row_in;
         b_rows_ff    <= b_rows_in;
         b_skip_ff    <= b_skip_in;
         bit_cnt_ff   <= bit_cnt_in;
         if (csr_we) begin
            case (csr_addr)
               REG_CLIP_LEFT:   clip_left_ff   <= csr_wdata;
               REG_CLIP_RIGHT:  clip_right_ff  <= csr_wdata;
               REG_CLIP_TOP:    clip_top_ff    <= csr_wdata[5:0];
               REG_CLIP_BOTTOM: clip_bottom_ff <= csr_wdata[6:0];
               REG_FG_BLACK:    fg_black_ff    <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      wx_ff       <= wx_in;
      wxe_ff      <= wxe_in;
      wy_ff       <= wy_in;
      wye_ff      <= wye_in;
      wvert_ff    <= wvert_in;
      wmode_ff    <= wmode_in;
      cxs_ff      <= cxs_in;
      cys_ff      <= cys_in;
      cbw_ff      <= cbw_in;
      cbr_ff      <= cbr_in;
      csrc_ff     <= csrc_in;
      crp_ff      <= crp_in;
      crc_ff      <= crc_in;
      rsp_data_ff <= rsp_data_in;
      rsp_act_ff  <= rsp_act_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_act_ff;

   // no command taken during the clearing sweep
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CLEAR) |-> !req_tready)
      else $error("command accepted during clear sweep");

   // bit counter never runs past one source byte
   a_bit_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      bit_cnt_ff[3] |-> (bit_cnt_ff[2:0] == 3'd0))
      else $error("blit bit counter overran");

   // a new result only comes from the read-out stage
   a_rsp_from_readout: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !$past(rsp_tvalid) && !$past(reset)) |-> ($past(state_ff) == S_RD_CAP))
      else $error("result raised outside read-out");

endmodule
